/* rtl/acs_pkg.sv */
// Shared constants for the adjacent cosine similarity block.
package acs_pkg;

	// Width of the dot product and squared norm accumulators.
	localparam int ACC_WIDTH = 40;
	// Similarity output width and the Q1.14 value of 1.0.
	localparam int SIM_W = 16;
	localparam int SIM_ONE = 16384;
	// Width of the unsigned quotient search value (0 .. SIM_ONE).
	localparam int Q_W = 15;
	// Width of the odd probe value 2q-1 and of its square.
	localparam int K_W = 15;
	localparam int K2_W = 2 * K_W;
	// Product of the two norms, and the wide compare accumulator.
	localparam int PROD_W = 2 * ACC_WIDTH;
	localparam int WIDE_W = PROD_W + K2_W;
	// Shared multiplier: signed operands one bit wider than a limb.
	localparam int LIMB_W = 32;
	localparam int MUL_W = LIMB_W + 1;
	// One probe per quotient bit below the top bit, plus the full-scale probe.
	localparam int SEARCH_STEPS = Q_W;

endpackage

/* rtl/acs_if.sv */
// Valid/ready channel interfaces for elements in and similarity scores out.
interface acs_elem_if import acs_pkg::*; #(
	parameter int ELEMENT_WIDTH = 16
) ();
	logic                            valid;
	logic                            ready;
	logic signed [ELEMENT_WIDTH-1:0] element;
	logic                            last_of_vector;
	logic                            starts_segment;

	modport source (output valid, output element, output last_of_vector,
		output starts_segment, input ready);
	modport sink (input valid, input element, input last_of_vector,
		input starts_segment, output ready);
endinterface

interface acs_score_if import acs_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [SIM_W-1:0] similarity;
	logic                    zero_norm;

	modport source (output valid, output similarity, output zero_norm, input ready);
	modport sink (input valid, input similarity, input zero_norm, output ready);
endinterface

/* rtl/adjacent_cosine_similarity_core.sv */
// Adjacent cosine similarity core: one shared multiplier under a small sequencer.
//
// The block takes embedding vectors one signed Q4.12 element per transfer on the
// elements channel; last_of_vector closes a vector and starts_segment on any of
// its elements opens a new sequence. At the close of every vector that has a
// predecessor in its segment, one transfer on the scores channel carries the
// cosine of the two vectors in signed Q1.14, rounded to nearest, or 0 with
// zero_norm set when either vector has a zero norm.
//
// Each element passes through the accepting state, then a dot product term,
// a square term and an accumulate, all through the one 33x33 multiplier.
// A compared vector with nonzero norms then runs the ratio search: the square
// of the dot magnitude and the product of the two norms, four limb products
// each, then up to 15 probes, every probe being one square and a three-limb
// wide product compared against the dot square.
// elements.ready is low while an element or a search is in progress.
//
// Reset clears the accumulators, the element count and the history; the
// stored previous vector is not cleared, it is only read below the length
// of the vector that wrote it. A finished score waits in an output register;
// the core takes further elements meanwhile and only holds its next score,
// with its element input closed, until the receiver has taken the waiting one.
module adjacent_cosine_similarity_core import acs_pkg::*; #(
	parameter int VECTOR_LENGTH = 192,
	parameter int ELEMENT_WIDTH = 16
) (
	input logic        clk,
	input logic        arst_n,
	acs_elem_if.sink   elements,
	acs_score_if.source scores
);

	localparam int CNT_W = $clog2(VECTOR_LENGTH + 1);
	localparam int IDX_W = $clog2(VECTOR_LENGTH);

	// Shift codes applied to a limb product before accumulation.
	localparam logic [1:0] SH_0  = 2'd0;
	localparam logic [1:0] SH_32 = 2'd1;
	localparam logic [1:0] SH_64 = 2'd2;

	typedef enum logic [9:0] {
		S_IDLE = 10'b00_0000_0001,
		S_DOT  = 10'b00_0000_0010,
		S_SQ   = 10'b00_0000_0100,
		S_ACC  = 10'b00_0000_1000,
		S_END  = 10'b00_0001_0000,
		S_MSQ  = 10'b00_0010_0000,
		S_PSQ  = 10'b00_0100_0000,
		S_KSQ  = 10'b00_1000_0000,
		S_TEST = 10'b01_0000_0000,
		S_OUT  = 10'b10_0000_0000
	} state_t;

	state_t state_q;

	// Previous vector store.
	logic [ELEMENT_WIDTH-1:0] prev_mem [VECTOR_LENGTH];

	// Running state of the stream.
	logic [ACC_WIDTH-1:0] dot_q;
	logic [ACC_WIDTH-1:0] prev_norm_q;
	logic [ACC_WIDTH-1:0] cur_norm_q;
	logic [CNT_W-1:0]     idx_q;
	logic [CNT_W-1:0]     prev_cnt_q;
	logic                 have_prev_q;
	logic                 skip_q;

	// Current element and the stored element at its position.
	logic [ELEMENT_WIDTH-1:0] cur_q;
	logic [ELEMENT_WIDTH-1:0] rd_q;
	logic                     last_q;
	logic                     active_q;

	// Shared multiplier and the wide accumulator behind it.
	logic signed [MUL_W-1:0]   mul_a;
	logic signed [MUL_W-1:0]   mul_b;
	logic [1:0]                mul_sh;
	logic                      mac_en;
	logic signed [2*MUL_W-1:0] mul_q;
	logic [1:0]                sh_q;
	logic                      add_q;
	logic [WIDE_W-1:0]         acc_q;
	logic [WIDE_W-1:0]         term;
	logic [WIDE_W-1:0]         acc_sum;
	logic                      acc_clr;

	// Ratio search registers.
	logic [ACC_WIDTH-1:0] mag_q;
	logic                 neg_q;
	logic [PROD_W-1:0]    msq_q;
	logic [PROD_W-1:0]    psq_q;
	logic [K2_W-1:0]      k2_q;
	logic [Q_W-1:0]       q_q;
	logic [3:0]           sb_q;
	logic [2:0]           cnt_q;
	logic [Q_W-1:0]       trial;
	logic [Q_W:0]         k_full;
	logic [K_W-1:0]       k_val;
	logic                 pass;
	logic [Q_W-1:0]       q_new;
	logic                 search_done;

	// Result staging and output register.
	logic signed [SIM_W-1:0] res_sim_q;
	logic                    res_zero_q;
	logic                    out_valid_q;
	logic signed [SIM_W-1:0] out_sim_q;
	logic                    out_zero_q;

	logic in_fire;
	logic idx_lt;
	logic use_prev;
	logic norm_zero;
	logic finish;
	logic out_load;

	assign elements.ready = (state_q == S_IDLE);
	assign in_fire  = elements.valid && elements.ready;
	assign idx_lt   = idx_q < CNT_W'(VECTOR_LENGTH);
	assign use_prev = idx_q < prev_cnt_q;
	assign norm_zero = (prev_norm_q == '0) || (cur_norm_q == '0);
	assign out_load = (state_q == S_OUT) && (!out_valid_q || scores.ready);

	// A vector is closed either directly when no score is due, or when the
	// score moves into the output register.
	assign finish = ((state_q == S_END) && !(have_prev_q && !skip_q)) || out_load;

	// The wide accumulator starts over at the end of every product sequence.
	assign acc_clr = (state_q == S_END) ||
		(((state_q == S_MSQ) || (state_q == S_PSQ)) && (cnt_q == 3'd4)) ||
		((state_q == S_KSQ) && (cnt_q == 3'd1)) ||
		((state_q == S_TEST) && (cnt_q == 3'd3));

	assign scores.valid      = out_valid_q;
	assign scores.similarity = out_sim_q;
	assign scores.zero_norm  = out_zero_q;

	// The search probes the full-scale code first, then builds the quotient
	// one bit at a time from the top; each probe tests (2q-1)^2 * P <= M * 2^30.
	always_comb begin
		if (sb_q == 4'd0) begin
			trial = Q_W'(SIM_ONE);
		end else begin
			trial = q_q | (Q_W'(1) << (4'(SEARCH_STEPS - 1) - sb_q));
		end
		k_full = {trial, 1'b0} - (Q_W+1)'(1);
		k_val  = k_full[K_W-1:0];
	end

	always_comb begin
		case (sh_q)
			SH_0:    term = WIDE_W'(mul_q[2*LIMB_W-1:0]);
			SH_32:   term = WIDE_W'({mul_q[2*LIMB_W-1:0], 32'd0});
			SH_64:   term = WIDE_W'({mul_q[2*LIMB_W-1:0], 64'd0});
			default: term = '0;
		endcase
		acc_sum = acc_q + (add_q ? term : '0);
	end

	assign pass        = acc_sum <= {msq_q, K2_W'(0)};
	assign q_new       = pass ? trial : q_q;
	assign search_done = ((sb_q == 4'd0) && pass) || (sb_q == 4'(SEARCH_STEPS - 1));

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_sh = SH_0;
		mac_en = 1'b0;
		case (state_q)
			S_DOT: begin
				if (use_prev) begin
					mul_a = {{(MUL_W-ELEMENT_WIDTH){rd_q[ELEMENT_WIDTH-1]}}, rd_q};
				end
				mul_b = {{(MUL_W-ELEMENT_WIDTH){cur_q[ELEMENT_WIDTH-1]}}, cur_q};
			end
			S_SQ: begin
				mul_a = {{(MUL_W-ELEMENT_WIDTH){cur_q[ELEMENT_WIDTH-1]}}, cur_q};
				mul_b = mul_a;
			end
			S_MSQ: begin
				mac_en = cnt_q < 3'd4;
				case (cnt_q)
					3'd0: begin
						mul_a = {1'b0, mag_q[LIMB_W-1:0]};
						mul_b = {1'b0, mag_q[LIMB_W-1:0]};
					end
					3'd1: begin
						mul_a  = {1'b0, mag_q[LIMB_W-1:0]};
						mul_b  = MUL_W'(mag_q[ACC_WIDTH-1:LIMB_W]);
						mul_sh = SH_32;
					end
					3'd2: begin
						mul_a  = MUL_W'(mag_q[ACC_WIDTH-1:LIMB_W]);
						mul_b  = {1'b0, mag_q[LIMB_W-1:0]};
						mul_sh = SH_32;
					end
					default: begin
						mul_a  = MUL_W'(mag_q[ACC_WIDTH-1:LIMB_W]);
						mul_b  = MUL_W'(mag_q[ACC_WIDTH-1:LIMB_W]);
						mul_sh = SH_64;
					end
				endcase
			end
			S_PSQ: begin
				mac_en = cnt_q < 3'd4;
				case (cnt_q)
					3'd0: begin
						mul_a = {1'b0, prev_norm_q[LIMB_W-1:0]};
						mul_b = {1'b0, cur_norm_q[LIMB_W-1:0]};
					end
					3'd1: begin
						mul_a  = {1'b0, prev_norm_q[LIMB_W-1:0]};
						mul_b  = MUL_W'(cur_norm_q[ACC_WIDTH-1:LIMB_W]);
						mul_sh = SH_32;
					end
					3'd2: begin
						mul_a  = MUL_W'(prev_norm_q[ACC_WIDTH-1:LIMB_W]);
						mul_b  = {1'b0, cur_norm_q[LIMB_W-1:0]};
						mul_sh = SH_32;
					end
					default: begin
						mul_a  = MUL_W'(prev_norm_q[ACC_WIDTH-1:LIMB_W]);
						mul_b  = MUL_W'(cur_norm_q[ACC_WIDTH-1:LIMB_W]);
						mul_sh = SH_64;
					end
				endcase
			end
			S_KSQ: begin
				mac_en = cnt_q == 3'd0;
				mul_a  = MUL_W'(k_val);
				mul_b  = MUL_W'(k_val);
			end
			S_TEST: begin
				mac_en = cnt_q < 3'd3;
				mul_b  = MUL_W'(k2_q);
				case (cnt_q)
					3'd0: begin
						mul_a = {1'b0, psq_q[LIMB_W-1:0]};
					end
					3'd1: begin
						mul_a  = {1'b0, psq_q[2*LIMB_W-1:LIMB_W]};
						mul_sh = SH_32;
					end
					default: begin
						mul_a  = MUL_W'(psq_q[PROD_W-1:2*LIMB_W]);
						mul_sh = SH_64;
					end
				endcase
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		sh_q  <= mul_sh;
		if (in_fire) begin
			cur_q    <= elements.element;
			last_q   <= elements.last_of_vector;
			active_q <= idx_lt;
		end
		if ((state_q == S_END) && have_prev_q && !skip_q) begin
			neg_q <= dot_q[ACC_WIDTH-1];
			mag_q <= dot_q[ACC_WIDTH-1] ? ACC_WIDTH'(0) - dot_q : dot_q;
			res_sim_q  <= '0;
			res_zero_q <= 1'b1;
		end
		if ((state_q == S_MSQ) && (cnt_q == 3'd4)) begin
			msq_q <= acc_sum[PROD_W-1:0];
		end
		if ((state_q == S_PSQ) && (cnt_q == 3'd4)) begin
			psq_q <= acc_sum[PROD_W-1:0];
		end
		if ((state_q == S_KSQ) && (cnt_q == 3'd1)) begin
			k2_q <= acc_sum[K2_W-1:0];
		end
		if ((state_q == S_TEST) && (cnt_q == 3'd3) && search_done) begin
			res_sim_q  <= neg_q ? SIM_W'(0) - SIM_W'(q_new) : SIM_W'(q_new);
			res_zero_q <= 1'b0;
		end
		if (out_load) begin
			out_sim_q  <= res_sim_q;
			out_zero_q <= res_zero_q;
		end
	end

	// Previous vector store: read when an element is taken, written once the
	// old entry has been consumed.
	always_ff @(posedge clk) begin
		if (in_fire && idx_lt) begin
			rd_q <= prev_mem[idx_q[IDX_W-1:0]];
		end
		if ((state_q == S_DOT) && active_q) begin
			prev_mem[idx_q[IDX_W-1:0]] <= cur_q;
		end
	end

	// Control state and accumulators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			dot_q       <= '0;
			prev_norm_q <= '0;
			cur_norm_q  <= '0;
			idx_q       <= '0;
			prev_cnt_q  <= '0;
			have_prev_q <= 1'b0;
			skip_q      <= 1'b0;
			add_q       <= 1'b0;
			acc_q       <= '0;
			cnt_q       <= '0;
			sb_q        <= '0;
			q_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			add_q <= mac_en;
			acc_q <= acc_clr ? '0 : acc_sum;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (scores.ready) begin
				out_valid_q <= 1'b0;
			end
			if (finish) begin
				prev_norm_q <= cur_norm_q;
				prev_cnt_q  <= idx_q;
				cur_norm_q  <= '0;
				dot_q       <= '0;
				idx_q       <= '0;
				have_prev_q <= 1'b1;
				skip_q      <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (elements.starts_segment) begin
							skip_q <= 1'b1;
						end
						state_q <= S_DOT;
					end
				end
				S_DOT: begin
					state_q <= S_SQ;
				end
				S_SQ: begin
					if (active_q) begin
						dot_q <= dot_q + mul_q[ACC_WIDTH-1:0];
					end
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (active_q) begin
						cur_norm_q <= cur_norm_q + mul_q[ACC_WIDTH-1:0];
						idx_q      <= idx_q + CNT_W'(1);
					end
					state_q <= last_q ? S_END : S_IDLE;
				end
				S_END: begin
					cnt_q <= '0;
					sb_q  <= '0;
					q_q   <= '0;
					if (have_prev_q && !skip_q) begin
						state_q <= norm_zero ? S_OUT : S_MSQ;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_MSQ, S_PSQ: begin
					if (cnt_q == 3'd4) begin
						cnt_q   <= '0;
						state_q <= (state_q == S_MSQ) ? S_PSQ : S_KSQ;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				S_KSQ: begin
					if (cnt_q == 3'd1) begin
						cnt_q   <= '0;
						state_q <= S_TEST;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				S_TEST: begin
					if (cnt_q == 3'd3) begin
						cnt_q <= '0;
						q_q   <= q_new;
						sb_q  <= sb_q + 4'd1;
						state_q <= search_done ? S_OUT : S_KSQ;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The element count never runs past the vector length.
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= CNT_W'(VECTOR_LENGTH))
		else $error("element count beyond vector length");

	// An accepted element keeps the input closed for the following cycles.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !elements.ready ##1 !elements.ready)
		else $error("input reopened while an element is in flight");

	// A zero-norm score always carries a zero similarity.
	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_zero_q |-> out_sim_q == '0)
		else $error("zero_norm score with nonzero similarity");

	// Scores stay within plus and minus one in Q1.14.
	a_sim_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_sim_q <= SIM_W'(SIM_ONE)) && (out_sim_q >= -SIM_W'(SIM_ONE)))
		else $error("similarity out of range");

	// A score is loaded only out of the result state.
	a_load_state: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_OUT)
		else $error("score loaded outside the result state");

endmodule

/* tb/acs_checker.sv */
// Score checker: predicts the similarity of each closed vector and compares the scores channel.
module acs_checker import acs_pkg::*; #(
	parameter int VECTOR_LENGTH = 192,
	parameter int ELEMENT_WIDTH = 16
) (
	input logic  clk,
	input logic  arst_n,
	acs_elem_if  elements,
	acs_score_if scores,
	output int   failures,
	output int   pending
);

	localparam int PRINT_LIMIT = 100;

	typedef struct {
		logic signed [SIM_W-1:0] similarity;
		logic                    zero_norm;
	} score_t;

	score_t expected_scores[$];

	// Predicted state of the core.
	bit signed [ELEMENT_WIDTH-1:0] held_vector[VECTOR_LENGTH];
	bit [ACC_WIDTH-1:0]            dot_acc;
	bit [ACC_WIDTH-1:0]            prev_energy;
	bit [ACC_WIDTH-1:0]            cur_energy;
	int                            elem_idx;
	int                            prev_len;
	bit                            have_prev;
	bit                            new_segment;

	task automatic report_mismatch(input string msg);
		failures++;
		if (failures <= PRINT_LIMIT)
			$display("mismatch at %0t: %s", $time, msg);
	endtask

	// Largest q in 0..SIM_ONE with (q - 1/2) <= SIM_ONE * mag / sqrt(norm_product),
	// which is the ratio rounded half up and saturated at 1.0.
	function automatic int rounded_cosine(bit [ACC_WIDTH-1:0] mag, bit [PROD_W-1:0] norm_product);
		bit [127:0] bound;
		bit [127:0] probe;
		int lo;
		int hi;
		int mid;
		bound = 128'(mag) * 128'(2 * SIM_ONE);
		bound = bound * bound;
		lo = 0;
		hi = SIM_ONE;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			probe = 128'(norm_product) * 128'(2 * mid - 1);
			probe = probe * 128'(2 * mid - 1);
			if (probe <= bound)
				lo = mid;
			else
				hi = mid - 1;
		end
		return lo;
	endfunction

	task automatic fold_element(input logic signed [ELEMENT_WIDTH-1:0] value, input logic last,
		input logic seg);
		longint             cur_val;
		longint             prev_val;
		bit [ACC_WIDTH-1:0] mag;
		bit                 neg;
		int                 q;
		score_t             want;
		cur_val = value;
		if (seg)
			new_segment = 1'b1;
		// Components past the vector length are dropped.
		if (elem_idx < VECTOR_LENGTH) begin
			prev_val = (elem_idx < prev_len) ? longint'(held_vector[elem_idx]) : 0;
			dot_acc = dot_acc + ACC_WIDTH'(prev_val * cur_val);
			cur_energy = cur_energy + ACC_WIDTH'(cur_val * cur_val);
			held_vector[elem_idx] = value;
			elem_idx++;
		end
		if (last) begin
			if (have_prev && !new_segment) begin
				if (prev_energy == 0 || cur_energy == 0) begin
					want.similarity = '0;
					want.zero_norm = 1'b1;
				end else begin
					neg = dot_acc[ACC_WIDTH-1];
					mag = neg ? (~dot_acc + 1'b1) : dot_acc;
					q = rounded_cosine(mag, PROD_W'(prev_energy) * PROD_W'(cur_energy));
					want.similarity = SIM_W'(neg ? -q : q);
					want.zero_norm = 1'b0;
				end
				expected_scores.insert(expected_scores.size(), want);
			end
			prev_energy = cur_energy;
			prev_len = elem_idx;
			cur_energy = '0;
			dot_acc = '0;
			elem_idx = 0;
			have_prev = 1'b1;
			new_segment = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		score_t want;
		if (!arst_n) begin
			dot_acc = '0;
			prev_energy = '0;
			cur_energy = '0;
			elem_idx = 0;
			prev_len = 0;
			have_prev = 1'b0;
			new_segment = 1'b0;
			expected_scores.delete();
			pending = 0;
		end else begin
			// A score can never stem from an element taken at the same edge.
			if (scores.valid === 1'b1 && scores.ready === 1'b1) begin
				if (expected_scores.size() == 0) begin
					report_mismatch($sformatf("unexpected score %0d, zero_norm %0b",
						scores.similarity, scores.zero_norm));
				end else begin
					want = expected_scores.pop_front();
					if (scores.similarity !== want.similarity)
						report_mismatch($sformatf("similarity %0d, expected %0d",
							scores.similarity, want.similarity));
					if (scores.zero_norm !== want.zero_norm)
						report_mismatch($sformatf("zero_norm %0b, expected %0b",
							scores.zero_norm, want.zero_norm));
				end
			end
			if (elements.valid === 1'b1 && elements.ready === 1'b1)
				fold_element(elements.element, elements.last_of_vector, elements.starts_segment);
			pending = expected_scores.size();
		end
	end

endmodule

/* tb/tb_adjacent_cosine_similarity_core.sv */
// Top of the testbench: clock, reset, element stimulus, score receiver and verdict.
module tb_adjacent_cosine_similarity_core;

	localparam int VECTOR_LENGTH = 192;
	localparam int ELEMENT_WIDTH = 16;
	// Elements to send in the random part.
	localparam int ITEM_TARGET = 1200;
	// The slowest correct stretch without any transfer is the receiver hold below
	// plus one ratio search; the limit leaves a wide margin.
	localparam int QUIET_LIMIT = 20000;
	localparam int HOLD_CYCLES = 1500;
	// Cycles to watch for stray scores once nothing is expected any more.
	localparam int SETTLE_CYCLES = 300;

	typedef logic signed [ELEMENT_WIDTH-1:0] elem_q_t[$];

	logic clk = 1'b0;
	logic arst_n;
	int   failures;
	int   pending;
	int   items_sent = 0;
	bit   sender_calm = 1'b0;

	acs_elem_if #(.ELEMENT_WIDTH(ELEMENT_WIDTH)) elements ();
	acs_score_if scores ();

	adjacent_cosine_similarity_core #(
		.VECTOR_LENGTH(VECTOR_LENGTH),
		.ELEMENT_WIDTH(ELEMENT_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.elements(elements),
		.scores(scores)
	);

	// The checker watches both channels on its own and reports the number of
	// failures and of scores still owed.
	acs_checker #(
		.VECTOR_LENGTH(VECTOR_LENGTH),
		.ELEMENT_WIDTH(ELEMENT_WIDTH)
	) score_check (
		.clk(clk),
		.arst_n(arst_n),
		.elements(elements),
		.scores(scores),
		.failures(failures),
		.pending(pending)
	);

	always #5 clk = ~clk;

	// One element transfer. Outside the calm stretch the sender sometimes drops
	// valid for a few cycles first, so gaps land both while the core is busy on
	// an element and while it runs a ratio search.
	task automatic send_element(input logic signed [ELEMENT_WIDTH-1:0] value, input bit last,
		input bit seg);
		if (!sender_calm && $urandom_range(0, 99) < 15) begin
			elements.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		elements.valid <= 1'b1;
		elements.element <= value;
		elements.last_of_vector <= last;
		elements.starts_segment <= seg;
		do @(posedge clk); while (elements.ready !== 1'b1);
		items_sent++;
	endtask

	// Sends a whole vector; seg_at names the element that carries the segment
	// mark, or -1 for none.
	task automatic send_vector(input elem_q_t vals, input int seg_at);
		for (int i = 0; i < vals.size(); i++)
			send_element(vals[i], i == vals.size() - 1, i == seg_at);
	endtask

	// Stops offering elements until every owed score has been taken. The check
	// runs at the falling edge, after the checker has seen the rising one.
	task automatic wait_for_scores();
		elements.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	// Element values by flavor: full random, extremes, small, or mostly zero.
	function automatic logic signed [ELEMENT_WIDTH-1:0] pick_value(input int flavor);
		logic signed [ELEMENT_WIDTH-1:0] extremes[5];
		extremes = '{16'h8000, 16'h7fff, 16'hffff, 16'h0000, 16'h0001};
		case (flavor)
			0: return ELEMENT_WIDTH'($urandom);
			1: return extremes[$urandom_range(0, 4)];
			2: return ELEMENT_WIDTH'(int'($urandom_range(0, 128)) - 64);
			default: return ($urandom_range(0, 3) == 0) ? ELEMENT_WIDTH'($urandom) : '0;
		endcase
	endfunction

	// Score receiver. It idles now and then, keeps ready high through a calm
	// window, and once holds off long enough that a second score finishes
	// behind the waiting one and the core has to stall its element input.
	initial begin : score_receiver
		int  cycle;
		int  taken;
		bit  held;
		cycle = 0;
		taken = 0;
		held = 1'b0;
		scores.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			cycle++;
			if (scores.valid === 1'b1 && scores.ready === 1'b1)
				taken++;
			if (!held && taken == 20) begin
				held = 1'b1;
				scores.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				scores.ready <= 1'b1;
			end else begin
				scores.ready <= (cycle >= 4000 && cycle < 8000) || $urandom_range(0, 99) >= 15;
			end
		end
	end

	// Watchdog: ends the run if no transfer happens on either channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((elements.valid === 1'b1 && elements.ready === 1'b1) ||
				(scores.valid === 1'b1 && scores.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin : stimulus
		elem_q_t vec;
		elem_q_t prior;
		int      len;
		int      len_roll;
		int      kind;
		int      flavor;
		int      seg_at;
		bit      paused;

		paused = 1'b0;
		arst_n <= 1'b0;
		elements.valid <= 1'b0;
		elements.element <= '0;
		elements.last_of_vector <= 1'b0;
		elements.starts_segment <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. The first vector after reset only fills the history.
		send_vector('{16'h7fff, 16'h8000, 16'sd1}, -1);
		// The same vector again: cosine of exactly one, at the saturation bound.
		send_vector('{16'h7fff, 16'h8000, 16'sd1}, -1);
		// Shorter all-zero vector: zero norm on the current side.
		send_vector('{16'sd0, 16'sd0}, -1);
		// Longer than its predecessor, whose norm was zero.
		send_vector('{16'sd5, 16'sd0, 16'sd0, 16'sd0}, -1);
		// Segment mark on the closing element: stored, but no score.
		send_vector('{16'sd3, -16'sd7}, 1);
		// A single element, shorter than the stored vector.
		send_vector('{16'h8000}, -1);
		send_vector('{16'sd12, -16'sd5, 16'sd7}, -1);
		// Exact negation: cosine of minus one.
		send_vector('{-16'sd12, 16'sd5, -16'sd7}, -1);
		// Orthogonal pair: a plain zero with the flag clear.
		send_vector('{16'sd1, 16'sd0}, -1);
		send_vector('{16'sd0, 16'sd1}, -1);
		wait_for_scores();

		// Random part: mostly short vectors so that scores come often, a few at
		// or past the full length, and some repeated, negated or perturbed
		// copies of the previous vector to land near plus and minus one.
		prior = '{16'sd0, 16'sd1};
		items_sent = 0;
		while (items_sent < ITEM_TARGET) begin
			if (!paused && items_sent >= 700) begin
				paused = 1'b1;
				wait_for_scores();
			end
			sender_calm = items_sent >= 300 && items_sent < 600;
			len_roll = $urandom_range(0, 99);
			if (len_roll < 2)
				len = $urandom_range(VECTOR_LENGTH + 1, VECTOR_LENGTH + 8);
			else if (len_roll < 4)
				len = VECTOR_LENGTH;
			else if (len_roll < 8)
				len = $urandom_range(9, 64);
			else
				len = $urandom_range(1, 8);
			kind = $urandom_range(0, 99);
			flavor = $urandom_range(0, 3);
			if (kind < 24 && $urandom_range(0, 3) != 0)
				len = prior.size();
			vec = {};
			for (int i = 0; i < len; i++) begin
				if (kind < 10 && i < prior.size())
					vec.insert(vec.size(), prior[i]);
				else if (kind < 18 && i < prior.size())
					vec.insert(vec.size(), -prior[i]);
				else if (kind < 24 && i < prior.size())
					vec.insert(vec.size(), prior[i] ^ ELEMENT_WIDTH'($urandom_range(0, 3)));
				else if (kind < 28)
					vec.insert(vec.size(), '0);
				else
					vec.insert(vec.size(), pick_value(flavor));
			end
			seg_at = ($urandom_range(0, 99) < 10) ? int'($urandom_range(0, len - 1)) : -1;
			send_vector(vec, seg_at);
			prior = vec;
		end

		// Drain: all owed scores, then a quiet window for anything unexpected.
		elements.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
